// ===== design/pkhk_pkg.sv =====
// Shared types, codes and reset constants of the pairing handshake keepalive block.
`default_nettype none

package pkhk_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int PADDR_W = 4;

  localparam logic [15:0] RETRY_INTERVAL_RESET     = 16'd1000;
  localparam logic [3:0]  RETRY_LIMIT_RESET        = 4'd5;
  localparam logic [15:0] HEARTBEAT_INTERVAL_RESET = 16'd5000;

  localparam logic [1:0] REG_RETRY_INTERVAL     = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT        = 2'd1;
  localparam logic [1:0] REG_HEARTBEAT_INTERVAL = 2'd2;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BEGIN  = 2'd1;
  localparam logic [1:0] OP_RX     = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] RX_OTHER     = 2'd0;
  localparam logic [1:0] RX_ACCEPT    = 2'd1;
  localparam logic [1:0] RX_ACK       = 2'd2;
  localparam logic [1:0] RX_HEARTBEAT = 2'd3;

  localparam logic       SEND_REQUEST   = 1'b0;
  localparam logic       SEND_HEARTBEAT = 1'b1;
  localparam logic [7:0] FLAGS_REQUEST  = 8'h01;
  localparam logic [7:0] FLAGS_HEARTBEAT = 8'h00;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_REQUESTING = 3'd1,
    MODE_WAITING    = 3'd2,
    MODE_CONNECTED  = 3'd3,
    MODE_TIMEOUT    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_BEGIN,
    CMD_CONNECT,
    CMD_RESTART,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  start_sequence;
    logic [1:0]  rx_kind;
    logic [47:0] rx_sender;
    logic [15:0] rx_sequence;
    logic [7:0]  rx_flags;
  } in_word_t;

  typedef struct packed {
    logic        send_valid;
    logic        send_kind;
    logic [15:0] send_sequence;
    logic [7:0]  send_flags;
    logic        add_peer;
    logic [47:0] peer_address;
    logic [7:0]  peer_flags;
    logic [2:0]  link_state;
    logic        paired;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  start_sequence;
    logic [47:0] sender;
    logic [15:0] sequence_num;
    logic [7:0]  flags;
  } cmd_t;

  typedef struct packed {
    logic [15:0] retry_interval;
    logic [3:0]  retry_limit;
    logic [15:0] heartbeat_interval;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/pkhk_front.sv =====
// Front end: accepts input words and classifies them into commands for the back end.
`default_nettype none

module pkhk_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  pkhk_pkg::in_word_t     in_word,
  output logic                   cmd_valid,
  input  wire logic              cmd_stall,
  output pkhk_pkg::cmd_t         cmd
);
  import pkhk_pkg::*;

  assign cmd_valid = in_valid;
  assign in_stall  = cmd_stall;

  // Packets of an unknown kind and the unused op code still produce a result word,
  // so they travel on as a no-op command.
  always_comb begin
    cmd.start_sequence = in_word.start_sequence;
    cmd.sender         = in_word.rx_sender;
    cmd.sequence_num   = in_word.rx_sequence;
    cmd.flags          = in_word.rx_flags;
    cmd.kind           = CMD_NONE;
    unique case (in_word.op)
      OP_TICK:  cmd.kind = CMD_TICK;
      OP_BEGIN: cmd.kind = CMD_BEGIN;
      OP_RX: begin
        case (in_word.rx_kind) inside
          RX_ACCEPT, RX_ACK: cmd.kind = CMD_CONNECT;
          RX_HEARTBEAT:      cmd.kind = CMD_RESTART;
          default:           cmd.kind = CMD_NONE;
        endcase
      end
      default:  cmd.kind = CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pkhk_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module pkhk_queue #(
  parameter int Depth = pkhk_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push_valid,
  output logic             push_stall,
  input  pkhk_pkg::cmd_t   push_cmd,
  output logic             pop_valid,
  input  wire logic        pop_stall,
  output pkhk_pkg::cmd_t   pop_cmd
);
  import pkhk_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_stall = (count == CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CntW'(1)))
    else $error("queue fill count missed a push");

  a_count_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - CntW'(1)))
    else $error("queue fill count missed a pop");

endmodule

`default_nettype wire

// ===== design/pkhk_back.sv =====
// Back end: link state machine, timers, sequence tracking and the output register.
`default_nettype none

module pkhk_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  pkhk_pkg::cfg_t      cfg,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  pkhk_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  wire logic           out_stall,
  output pkhk_pkg::out_word_t out_word
);
  import pkhk_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] elapsed;
  logic [15:0] elapsed_next;
  logic [15:0] elapsed_inc;
  logic [3:0]  retries;
  logic [3:0]  retries_next;
  logic [7:0]  request_sequence;
  logic [7:0]  request_sequence_next;
  logic [15:0] last_sequence;
  logic [15:0] last_sequence_next;
  logic [47:0] stored_peer;
  logic [47:0] stored_peer_next;
  out_word_t   result;
  logic        pop;

  assign cmd_stall = out_valid && out_stall;
  assign pop       = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      elapsed          <= '0;
      retries          <= '0;
      request_sequence <= '0;
      last_sequence    <= '0;
      stored_peer      <= '0;
    end else if (pop) begin
      mode             <= mode_next;
      elapsed          <= elapsed_next;
      retries          <= retries_next;
      request_sequence <= request_sequence_next;
      last_sequence    <= last_sequence_next;
      stored_peer      <= stored_peer_next;
    end
  end

  always_comb begin
    mode_next             = mode;
    elapsed_next          = elapsed;
    retries_next          = retries;
    request_sequence_next = request_sequence;
    last_sequence_next    = last_sequence;
    stored_peer_next      = stored_peer;
    result                = '0;
    elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;

    unique case (cmd.kind)
      CMD_TICK: begin
        elapsed_next = elapsed_inc;
        if (mode == MODE_REQUESTING || mode == MODE_WAITING) begin
          if (elapsed_inc >= cfg.retry_interval) begin
            if (retries >= cfg.retry_limit) begin
              mode_next    = MODE_TIMEOUT;
              elapsed_next = '0;
              retries_next = '0;
            end else begin
              last_sequence_next   = last_sequence + 16'd1;
              result.send_valid    = 1'b1;
              result.send_kind     = SEND_REQUEST;
              result.send_sequence = {8'd0, request_sequence};
              result.send_flags    = FLAGS_REQUEST;
              elapsed_next         = '0;
              retries_next = (retries == 4'hF) ? retries : retries + 4'd1;
              // The first request moves to waiting and starts the retry count afresh.
              if (mode == MODE_REQUESTING) begin
                mode_next    = MODE_WAITING;
                retries_next = '0;
              end
            end
          end
        end else if (mode == MODE_CONNECTED) begin
          if (elapsed_inc >= cfg.heartbeat_interval) begin
            last_sequence_next   = last_sequence + 16'd1;
            result.send_valid    = 1'b1;
            result.send_kind     = SEND_HEARTBEAT;
            result.send_sequence = last_sequence + 16'd1;
            result.send_flags    = FLAGS_HEARTBEAT;
            elapsed_next         = '0;
          end
        end
      end
      CMD_BEGIN: begin
        request_sequence_next = cmd.start_sequence;
        mode_next             = MODE_REQUESTING;
        elapsed_next          = '0;
        retries_next          = '0;
      end
      CMD_CONNECT: begin
        stored_peer_next   = cmd.sender;
        last_sequence_next = cmd.sequence_num;
        result.add_peer    = 1'b1;
        result.peer_flags  = cmd.flags;
        mode_next          = MODE_CONNECTED;
        elapsed_next       = '0;
        retries_next       = '0;
      end
      CMD_RESTART: begin
        elapsed_next = '0;
      end
      default: begin
      end
    endcase

    result.peer_address = stored_peer_next;
    result.link_state   = mode_next;
    result.paired       = (mode_next == MODE_CONNECTED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= result;
    end
  end

  a_add_connects: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.add_peer) |-> (out_word.link_state == MODE_CONNECTED))
    else $error("peer registration without a connected link");

  a_heartbeat_connected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.send_valid && out_word.send_kind == SEND_HEARTBEAT)
      |-> (out_word.link_state == MODE_CONNECTED))
    else $error("heartbeat sent while not connected");

  a_no_send_and_add: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.add_peer) |-> !out_word.send_valid)
    else $error("send and peer registration in one word");

endmodule

`default_nettype wire

// ===== design/pairing_handshake_keepalive.sv =====
// Top level of the pairing handshake keepalive block: register port, front end, queue, back end.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid/in_stall    in_word   (tick, begin or received packet)
//   output    out        out_valid/out_stall  out_word  (one result word per input word)
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// One result word per input word. The front end classifies a word as it is accepted and writes
// it into the command queue; the back end runs one command per cycle into its output register
// unless the output stalls, so a word is taken every cycle while the queue has room; a result
// passes a queue entry, then the output register. Reset (synchronous, active high) idles the
// link, clears timers, peer and queue, and restores the register defaults. An output stall
// holds the output register and then fills the queue; the input stalls only when it is full.
`default_nettype none

module pairing_handshake_keepalive #(
  parameter int QueueDepth = pkhk_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  pkhk_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pkhk_pkg::out_word_t                out_word,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pkhk_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import pkhk_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;
  logic [1:0] reg_index;

  logic       front_valid;
  logic       front_stall;
  cmd_t       front_cmd;
  logic       back_valid;
  logic       back_stall;
  cmd_t       back_cmd;

  // The register port never waits. Registers sit at word addresses, so the index is
  // the address without its byte offset; writes beyond the last register are dropped.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_interval     <= RETRY_INTERVAL_RESET;
      cfg.retry_limit        <= RETRY_LIMIT_RESET;
      cfg.heartbeat_interval <= HEARTBEAT_INTERVAL_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_RETRY_INTERVAL:     cfg.retry_interval     <= pwdata[15:0];
        REG_RETRY_LIMIT:        cfg.retry_limit        <= pwdata[3:0];
        REG_HEARTBEAT_INTERVAL: cfg.heartbeat_interval <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_RETRY_INTERVAL:     prdata = {16'd0, cfg.retry_interval};
      REG_RETRY_LIMIT:        prdata = {28'd0, cfg.retry_limit};
      REG_HEARTBEAT_INTERVAL: prdata = {16'd0, cfg.heartbeat_interval};
      default:                prdata = '0;
    endcase
  end

  // Front end: turns each word into a command.
  pkhk_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cmd_valid (front_valid),
    .cmd_stall (front_stall),
    .cmd       (front_cmd)
  );

  // Command queue decouples the input handshake from output back-pressure.
  pkhk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_stall  (back_stall),
    .pop_cmd    (back_cmd)
  );

  // Back end: the link state machine and the registered result word.
  pkhk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (back_valid),
    .cmd_stall (back_stall),
    .cmd       (back_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== bench/tb_pairing_handshake_keepalive.sv =====
// Self-checking testbench for the pairing handshake keepalive block.
`timescale 1ns / 1ps

module tb_pairing_handshake_keepalive;
  import pkhk_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legitimate quiet stretch is the receiver hold-off below.
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEMS_PER_RUN = 175;
  localparam int RANDOM_RUNS   = 8;
  localparam int HOLD_RUN      = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  pairing_handshake_keepalive DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // Words waiting to be offered, and results the link predictor has worked out
  // for words the block already took.
  in_word_t  words_to_send[$];
  out_word_t link_results_due[$];

  int words_queued = 0;
  int words_taken  = 0;
  int live_items   = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  // Idling odds of the two sides, changed once per run.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  // Predictor copy of the timer registers and of the link state.
  logic [15:0] cfg_retry_interval     = RETRY_INTERVAL_RESET;
  logic [3:0]  cfg_retry_limit        = RETRY_LIMIT_RESET;
  logic [15:0] cfg_heartbeat_interval = HEARTBEAT_INTERVAL_RESET;

  mode_t       link_mode   = MODE_IDLE;
  logic [15:0] elapsed_ms  = '0;
  logic [3:0]  retry_count = '0;
  logic [7:0]  request_seq = '0;
  logic [15:0] seq_counter = '0;
  logic [47:0] peer_addr   = '0;

  // Every change of mode restarts the timer and the retry count.
  function automatic void enter_mode(mode_t next);
    link_mode   = next;
    elapsed_ms  = '0;
    retry_count = '0;
  endfunction

  // Advances the link state by one input word and returns the result word
  // the block must produce for it.
  function automatic out_word_t link_step(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.op)
      OP_TICK: begin
        if (elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 16'd1;
        if (link_mode == MODE_REQUESTING || link_mode == MODE_WAITING) begin
          if (elapsed_ms >= cfg_retry_interval) begin
            if (retry_count >= cfg_retry_limit) begin
              enter_mode(MODE_TIMEOUT);
            end else begin
              // The packet builder bumps the running sequence even though a
              // request carries the start sequence.
              seq_counter     = seq_counter + 16'd1;
              r.send_valid    = 1'b1;
              r.send_kind     = SEND_REQUEST;
              r.send_sequence = {8'h00, request_seq};
              r.send_flags    = FLAGS_REQUEST;
              elapsed_ms      = '0;
              if (retry_count != 4'hF) retry_count = retry_count + 4'd1;
              if (link_mode == MODE_REQUESTING) enter_mode(MODE_WAITING);
            end
          end
        end else if (link_mode == MODE_CONNECTED) begin
          if (elapsed_ms >= cfg_heartbeat_interval) begin
            seq_counter     = seq_counter + 16'd1;
            r.send_valid    = 1'b1;
            r.send_kind     = SEND_HEARTBEAT;
            r.send_sequence = seq_counter;
            r.send_flags    = FLAGS_HEARTBEAT;
            elapsed_ms      = '0;
          end
        end
      end
      OP_BEGIN: begin
        request_seq = w.start_sequence;
        enter_mode(MODE_REQUESTING);
      end
      OP_RX: begin
        if (w.rx_kind == RX_ACCEPT || w.rx_kind == RX_ACK) begin
          peer_addr    = w.rx_sender;
          seq_counter  = w.rx_sequence;
          r.add_peer   = 1'b1;
          r.peer_flags = w.rx_flags;
          enter_mode(MODE_CONNECTED);
        end else if (w.rx_kind == RX_HEARTBEAT) begin
          elapsed_ms = '0;
        end
      end
      default: begin
      end
    endcase
    r.peer_address = peer_addr;
    r.link_state   = link_mode;
    r.paired       = (link_mode == MODE_CONNECTED);
    return r;
  endfunction

  function automatic string show_result(out_word_t r);
    return $sformatf({"send %0d kind %0d seq %h flags %h add %0d peer %h pflags %h",
                      " state %0d paired %0d"},
                     r.send_valid, r.send_kind, r.send_sequence, r.send_flags, r.add_peer,
                     r.peer_address, r.peer_flags, r.link_state, r.paired);
  endfunction

  // Sender: a word stays on the bus until it is taken; a new one (or a gap)
  // is chosen only after the previous word went through.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word  <= words_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the block back
  // up all the way to its input while the sender keeps offering words.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: results are checked before this edge's input word is predicted,
  // so a result can never be matched against a word taken at the same edge.
  always @(posedge clk) begin : monitor
    out_word_t due;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (link_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: %s", show_result(out_word));
        end else begin
          due = link_results_due.pop_front();
          if (out_word.send_valid !== due.send_valid ||
              out_word.send_kind !== due.send_kind ||
              out_word.send_sequence !== due.send_sequence ||
              out_word.send_flags !== due.send_flags ||
              out_word.add_peer !== due.add_peer ||
              out_word.peer_address !== due.peer_address ||
              out_word.peer_flags !== due.peer_flags ||
              out_word.link_state !== due.link_state ||
              out_word.paired !== due.paired) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       show_result(due), show_result(out_word));
          end
        end
      end
      if (in_valid && !in_stall) begin
        link_results_due.push_back(link_step(in_word));
        words_taken++;
      end
    end
  end

  // Watchdog: ends a run in which neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t make_word(logic [1:0] op, logic [7:0] start, logic [1:0] kind,
                                         logic [47:0] sender, logic [15:0] seq,
                                         logic [7:0] flags);
    in_word_t w;
    w.op             = op;
    w.start_sequence = start;
    w.rx_kind        = kind;
    w.rx_sender      = sender;
    w.rx_sequence    = seq;
    w.rx_flags       = flags;
    return w;
  endfunction

  // Every field carries random bits, including the ones the operation ignores.
  function automatic in_word_t random_word(logic [1:0] op);
    return make_word(op, 8'($urandom), 2'($urandom), 48'({$urandom, $urandom}),
                     16'($urandom), 8'($urandom));
  endfunction

  task automatic queue_word(in_word_t w);
    words_to_send.push_back(w);
    words_queued++;
    // Ignored words (unused op code, unknown packet kind) do not count.
    if (w.op != OP_UNUSED && !(w.op == OP_RX && w.rx_kind == RX_OTHER)) live_items++;
  endtask

  // A run of ticks, now and then broken by a received heartbeat, an unknown
  // packet or an unused op code.
  task automatic queue_ticks(int count);
    in_word_t w;
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) begin
        w = random_word(OP_RX);
        w.rx_kind = $urandom_range(0, 1) ? RX_HEARTBEAT : RX_OTHER;
        if ($urandom_range(0, 3) == 0) w.op = OP_UNUSED;
      end else begin
        w = random_word(OP_TICK);
      end
      queue_word(w);
    end
  endtask

  // Mostly well-formed sequences: a begin followed by ticks that can retry
  // and time out, or a connect followed by ticks that can draw heartbeats. The
  // rest are single words of any kind.
  task automatic queue_scenario();
    int       pick;
    in_word_t w;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      queue_word(random_word(OP_BEGIN));
      queue_ticks($urandom_range(1, 40));
    end else if (pick < 70) begin
      w = random_word(OP_RX);
      w.rx_kind = $urandom_range(0, 1) ? RX_ACCEPT : RX_ACK;
      queue_word(w);
      queue_ticks($urandom_range(1, 30));
    end else begin
      queue_word(random_word(2'($urandom_range(0, 3))));
    end
  endtask

  // Waits until every offered word has been taken and answered.
  task automatic drain();
    while (words_taken != words_queued || link_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RETRY_INTERVAL:     cfg_retry_interval = value;
      REG_RETRY_LIMIT:        cfg_retry_limit = value[3:0];
      REG_HEARTBEAT_INTERVAL: cfg_heartbeat_interval = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_timers(logic [15:0] retry_iv, logic [3:0] limit, logic [15:0] beat_iv);
    drain();
    cfg_write(REG_RETRY_INTERVAL, retry_iv);
    cfg_write(REG_RETRY_LIMIT, {12'h000, limit});
    cfg_write(REG_HEARTBEAT_INTERVAL, beat_iv);
  endtask

  initial begin
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 75, 0, 7};
    recv_pct = '{0, 0, 75, 7};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset timer values: an unused op code with all
    // bits set, ignored and restarting packets while idle, a begin with the
    // lowest start sequence and a connect with all-zero sender, sequence and flags.
    queue_word(make_word(OP_UNUSED, '1, '1, '1, '1, '1));
    queue_word(make_word(OP_TICK, '0, '0, '0, '0, '0));
    queue_word(make_word(OP_RX, '1, RX_OTHER, '1, '1, '1));
    queue_word(make_word(OP_RX, '0, RX_HEARTBEAT, '1, '1, '1));
    queue_word(make_word(OP_BEGIN, 8'h00, '0, '0, '0, '0));
    queue_word(make_word(OP_TICK, '1, '1, '1, '1, '1));
    queue_word(make_word(OP_RX, '1, RX_ACK, '0, '0, '0));
    queue_word(make_word(OP_TICK, '0, '0, '0, '0, '0));

    // Short timers so that the directed words reach a retry, a timeout, a
    // heartbeat whose sequence wraps past all ones, and a begin while connected.
    set_timers(16'd2, 4'd1, 16'd2);
    queue_word(make_word(OP_BEGIN, 8'hFF, '0, '0, '0, '0));
    repeat (6) queue_word(make_word(OP_TICK, '0, '0, '0, '0, '0));
    queue_word(make_word(OP_RX, '0, RX_ACCEPT, '1, 16'hFFFF, 8'hFF));
    repeat (3) queue_word(make_word(OP_TICK, '0, '0, '0, '0, '0));
    queue_word(make_word(OP_RX, '0, RX_HEARTBEAT, '0, '0, '0));
    queue_word(make_word(OP_TICK, '0, '0, '0, '0, '0));
    queue_word(make_word(OP_BEGIN, 8'h5A, '0, '0, '0, '0));
    repeat (2) queue_word(make_word(OP_TICK, '0, '0, '0, '0, '0));

    // Random runs, each with its own timer values and idling pattern. Zero
    // intervals fire on every tick; the largest ones never fire here.
    live_items = 0;
    for (int run = 0; run < RANDOM_RUNS; run++) begin
      case (run)
        1:       set_timers(16'd0, 4'd0, 16'd0);
        3:       set_timers(16'hFFFF, 4'hF, 16'hFFFF);
        4:       set_timers(16'd1, 4'hF, 16'd1);
        7:       set_timers(16'd1, 4'd0, 16'd2);
        default: set_timers(16'($urandom_range(1, 6)), 4'($urandom_range(0, 15)),
                            16'($urandom_range(1, 10)));
      endcase
      send_idle_pct  <= send_pct[run % 4];
      recv_stall_pct <= recv_pct[run % 4];
      if (run == HOLD_RUN) hold_go <= 1'b1;
      while (live_items < ITEMS_PER_RUN * (run + 1)) queue_scenario();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && link_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
